/* rtl/rtxt_pkg.sv */
package rtxt_pkg;

  // Table depth default and the per-tick resend cap
  localparam int unsigned TableSlotsDef = 16;
  localparam int unsigned MaxResults    = 16;
  localparam int unsigned CntW          = $clog2(MaxResults + 1);

  localparam logic [15:0] TimeoutReset = 16'd500;

  typedef enum logic [1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ASSIGNED = 3'd0,
    KIND_ACKED    = 3'd1,
    KIND_UNKNOWN  = 3'd2,
    KIND_RESEND   = 3'd3,
    KIND_FULL     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_EVAL  = 2'd2,
    ST_FLUSH = 2'd3
  } state_e;

  typedef struct packed {
    logic [15:0] seq;
    logic [7:0]  peer;
    logic [31:0] first_time;
    logic [31:0] last_time;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic rd_en;
    logic next_slot;
    logic commit_hit;
    logic commit_miss;
    logic flush;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic hit;
    logic last_slot;
    logic cap_hit;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

/* rtl/rtxt_ctrl.sv */
module rtxt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       cmd_i,
  output logic             in_ready_o,
  input  rtxt_pkg::sts_t   sts_i,
  output rtxt_pkg::ctl_t   ctl_o
);
  import rtxt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          if (cmd_e'(cmd_i) != CMD_NOP) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        ctl_o.rd_en = 1'b1;
        state_d     = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.cmd == CMD_TICK) begin
          if (sts_i.hit) begin
            // a held resend must move out before the new one takes its place
            if (!sts_i.pend_valid || sts_i.out_free) begin
              ctl_o.commit_hit = 1'b1;
              if (sts_i.cap_hit || sts_i.last_slot) begin
                state_d = ST_FLUSH;
              end else begin
                ctl_o.next_slot = 1'b1;
                state_d         = ST_READ;
              end
            end
          end else if (sts_i.last_slot) begin
            state_d = ST_FLUSH;
          end else begin
            ctl_o.next_slot = 1'b1;
            state_d         = ST_READ;
          end
        end else begin
          if (sts_i.hit) begin
            if (sts_i.out_free) begin
              ctl_o.commit_hit = 1'b1;
              state_d          = ST_IDLE;
            end
          end else if (sts_i.last_slot) begin
            if (sts_i.out_free) begin
              ctl_o.commit_miss = 1'b1;
              state_d           = ST_IDLE;
            end
          end else begin
            ctl_o.next_slot = 1'b1;
            state_d         = ST_READ;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          ctl_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/rtxt_dpath.sv */
module rtxt_dpath #(
  parameter int unsigned TableSlots = rtxt_pkg::TableSlotsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rtxt_pkg::ctl_t   ctl_i,
  output rtxt_pkg::sts_t   sts_o,
  input  logic [1:0]       cmd_i,
  input  logic [15:0]      ack_id_i,
  input  logic [7:0]       dest_handle_i,
  input  logic             timeout_we_i,
  input  logic [15:0]      timeout_ticks_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [2:0]       kind_o,
  output logic [15:0]      packet_id_o,
  output logic [7:0]       peer_tag_o,
  output logic [31:0]      rtt_ticks_o,
  output logic             last_o
);
  import rtxt_pkg::*;

  localparam int unsigned IdxW = (TableSlots > 1) ? $clog2(TableSlots) : 1;

  // control state
  cmd_e                  cmd_q;
  logic [31:0]           now_q;
  logic [15:0]           seq_q;
  logic [15:0]           timeout_q;
  logic [TableSlots-1:0] valid_q;
  logic [IdxW-1:0]       idx_q;
  logic [CntW-1:0]       cnt_q;
  logic                  pend_valid_q;
  logic                  out_valid_q, out_valid_d;

  // payload
  logic [15:0] ack_q;
  logic [7:0]  dest_q;
  entry_t      rdata_q;
  entry_t      mem [TableSlots];
  logic [15:0] pend_id_q;
  logic [7:0]  pend_peer_q;
  kind_e       out_kind_q, out_kind_d;
  logic [15:0] out_id_q, out_id_d;
  logic [7:0]  out_peer_q, out_peer_d;
  logic [31:0] out_rtt_q, out_rtt_d;
  logic        out_last_q, out_last_d;

  logic        out_load;
  logic        mem_we;
  entry_t      mem_wdata;
  logic [31:0] age;
  logic        due;
  logic        cur_valid;
  logic        hit;
  logic        is_send, is_ack, is_tick;

  assign is_send = (cmd_q == CMD_SEND);
  assign is_ack  = (cmd_q == CMD_ACK);
  assign is_tick = (cmd_q == CMD_TICK);

  assign age       = now_q - rdata_q.last_time;
  assign due       = age > {16'b0, timeout_q};
  assign cur_valid = valid_q[idx_q];

  always_comb begin
    case (cmd_q)
      CMD_SEND: hit = !cur_valid;
      CMD_ACK:  hit = cur_valid && (rdata_q.seq == ack_q);
      CMD_TICK: hit = cur_valid && due;
      default:  hit = 1'b0;
    endcase
  end

  assign sts_o.cmd        = cmd_q;
  assign sts_o.hit        = hit;
  assign sts_o.last_slot  = (idx_q == IdxW'(TableSlots - 1));
  assign sts_o.cap_hit    = (cnt_q == CntW'(MaxResults - 1));
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // table memory: one write, one registered read
  assign mem_we = ctl_i.commit_hit && (is_send || is_tick);

  always_comb begin
    mem_wdata = rdata_q;
    if (is_send) begin
      mem_wdata.seq        = seq_q;
      mem_wdata.peer       = dest_q;
      mem_wdata.first_time = now_q;
    end
    mem_wdata.last_time = now_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= mem_wdata;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q        <= CMD_NOP;
      now_q        <= '0;
      seq_q        <= '0;
      timeout_q    <= TimeoutReset;
      valid_q      <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (timeout_we_i) begin
        timeout_q <= timeout_ticks_i;
      end
      if (ctl_i.load) begin
        cmd_q <= cmd_e'(cmd_i);
        idx_q <= '0;
        cnt_q <= '0;
        if (cmd_e'(cmd_i) == CMD_TICK) begin
          now_q <= now_q + 32'd1;
        end
      end
      if (ctl_i.next_slot) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (ctl_i.commit_hit) begin
        if (is_send) begin
          valid_q[idx_q] <= 1'b1;
          seq_q          <= seq_q + 16'd1;
        end
        if (is_ack) begin
          valid_q[idx_q] <= 1'b0;
        end
        if (is_tick) begin
          cnt_q        <= cnt_q + CntW'(1);
          pend_valid_q <= 1'b1;
        end
      end
      if (ctl_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      ack_q  <= ack_id_i;
      dest_q <= dest_handle_i;
    end
    if (ctl_i.commit_hit && is_tick) begin
      pend_id_q   <= rdata_q.seq;
      pend_peer_q <= rdata_q.peer;
    end
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_id_q   <= out_id_d;
      out_peer_q <= out_peer_d;
      out_rtt_q  <= out_rtt_d;
      out_last_q <= out_last_d;
    end
  end

  // output beat selection
  always_comb begin
    out_load   = 1'b0;
    out_kind_d = KIND_RESEND;
    out_id_d   = pend_id_q;
    out_peer_d = pend_peer_q;
    out_rtt_d  = '0;
    out_last_d = 1'b1;
    if (ctl_i.commit_hit) begin
      if (is_send) begin
        out_load   = 1'b1;
        out_kind_d = KIND_ASSIGNED;
        out_id_d   = seq_q;
        out_peer_d = dest_q;
      end else if (is_ack) begin
        out_load   = 1'b1;
        out_kind_d = KIND_ACKED;
        out_id_d   = ack_q;
        out_peer_d = rdata_q.peer;
        out_rtt_d  = now_q - rdata_q.first_time;
      end else begin
        // a newer resend follows, so the held one is not the final beat
        out_load   = pend_valid_q;
        out_last_d = 1'b0;
      end
    end else if (ctl_i.commit_miss) begin
      out_load = 1'b1;
      if (is_send) begin
        out_kind_d = KIND_FULL;
        out_id_d   = seq_q;
        out_peer_d = dest_q;
      end else begin
        out_kind_d = KIND_UNKNOWN;
        out_id_d   = ack_q;
        out_peer_d = '0;
      end
    end else if (ctl_i.flush) begin
      out_load = 1'b1;
    end
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || out_load;

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign packet_id_o = out_id_q;
  assign peer_tag_o  = out_peer_q;
  assign rtt_ticks_o = out_rtt_q;
  assign last_o      = out_last_q;

endmodule

/* rtl/retransmit_timer_table_unit.sv */
// Sequence: send/ack is accepted, then slots are read and evaluated to a hit or the end;
//   a tick scans to the last slot or resend cap, then flushes; a NOP is only accepted.
// Throughput: one item at a time, set by the single read port of the slot table
//   (read in ST_READ, evaluate in ST_EVAL); output back-pressure can stall the block.
// Reset (async, active low): time, sequence counter and all slot valid bits clear,
//   timeout returns to 500; no clearing pass, the block takes items right after reset.
module retransmit_timer_table_unit #(
  parameter int unsigned TABLE_SLOTS = rtxt_pkg::TableSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command beats
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] ack_id_i,
  input  logic [7:0]  dest_handle_i,
  // timeout register write
  input  logic        timeout_we_i,
  input  logic [15:0] timeout_ticks_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [15:0] packet_id_o,
  output logic [7:0]  peer_tag_o,
  output logic [31:0] rtt_ticks_o,
  output logic        last_o
);
  import rtxt_pkg::*;

  // The controller walks the slot table one entry per read/evaluate pair:
  //  - send: stops at the lowest free slot, else reports the table full
  //  - ack:  stops at the lowest valid slot holding that id, else unknown
  //  - tick: visits slots to the last or the resend cap; each due entry restarts
  //          its timer and its resend is held one step so the final beat can carry last
  // The output register lets a finished beat wait while the scan goes on.
  ctl_t ctl;
  sts_t sts;

  rtxt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  rtxt_dpath #(
    .TableSlots (TABLE_SLOTS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .cmd_i           (cmd_i),
    .ack_id_i        (ack_id_i),
    .dest_handle_i   (dest_handle_i),
    .timeout_we_i    (timeout_we_i),
    .timeout_ticks_i (timeout_ticks_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .packet_id_o     (packet_id_o),
    .peer_tag_o      (peer_tag_o),
    .rtt_ticks_o     (rtt_ticks_o),
    .last_o          (last_o)
  );

endmodule

/* rtl/rtxt_checker.sv */
module rtxt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  cmd_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  kind_o,
  input logic [15:0] packet_id_o,
  input logic [7:0]  peer_tag_o,
  input logic [31:0] rtt_ticks_o,
  input logic        last_o
);
  import rtxt_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(packet_id_o) && $stable(peer_tag_o) && $stable(rtt_ticks_o))
    else $error("result beat changed while stalled");

  // accepting a real command moves the block out of idle, so ready drops
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (cmd_i != CMD_NOP) |=> !in_ready_o)
    else $error("ready right after accepting a command");

  // only resends come in groups
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_RESEND) |-> last_o)
    else $error("non-resend beat without last");

  // unknown ack and resend carry no round-trip time
  a_no_rtt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_UNKNOWN || kind_o == KIND_RESEND)
      |-> rtt_ticks_o == 32'd0)
    else $error("round-trip time on a beat that has none");

endmodule

bind retransmit_timer_table_unit rtxt_checker u_rtxt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .packet_id_o (packet_id_o),
  .peer_tag_o  (peer_tag_o),
  .rtt_ticks_o (rtt_ticks_o),
  .last_o      (last_o)
);
